// ----- rtl/core/scfl_pkg.sv -----
// ----------------------------------------------------------------------------
// scfl_pkg
// shared types and constants for the serial command frame link
// ----------------------------------------------------------------------------
package scfl_pkg;

    // result kinds carried on the master-side tuser
    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_CMD  = 2'd1;
    localparam logic [1:0] KIND_PAY  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_ACK     = 2'd0;
    localparam logic [1:0] CFG_NACK    = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT = 2'd2;

    // configuration reset values
    localparam logic [7:0]  ACK_RESET     = 8'd6;
    localparam logic [7:0]  NACK_RESET    = 8'd21;
    localparam logic [15:0] TIMEOUT_RESET = 16'd5000;

    // framing constants
    localparam int HDR_LEN    = 3;
    localparam int RESP_BYTES = 4;
    localparam int TX_BYTES   = RESP_BYTES + 1;

    // one result transaction towards the output register
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [7:0] group;
        logic [7:0] code;
        logic [4:0] length;
        logic       last;
    } scfl_result_t;

endpackage

// ----- rtl/core/serial_command_frame_link_top.sv -----
// ----------------------------------------------------------------------------
// serial_command_frame_link_top
// link layer of a byte-serial command protocol with header/payload checking
// ----------------------------------------------------------------------------
// Slave-side stream: one transaction is either a byte received from the host
// (tuser 0, with its idle gap) or a response from the command handler
// (tuser 1, with size and up to four payload bytes). Master-side stream: bytes
// for the host, a command-ready record and the command payload bytes; tlast
// marks the final result of each input transaction.
// One input is taken at a time: the block accepts, decides in S_EXEC, then
// emits one direct byte per cycle while the output register has room; each
// payload byte is first read from the registered payload store in S_RD and
// then sent from S_DATA. After acceptance the block passes through S_EXEC and
// S_SEND before the first result is registered in the output register.
// The output register lets the next input be accepted while the last result
// still waits; a stalled receiver holds the sequencer and, through it, input.
// Reset returns framing to the header phase and loads the register defaults;
// header and payload stores are not cleared and need no clearing pass.
// Configuration writes take effect at once and are meant for idle periods.
// ----------------------------------------------------------------------------
module serial_command_frame_link_top
    import scfl_pkg::*;
#(
    parameter int MAX_PAYLOAD = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // rx_byte, gap_ticks, resp_size, resp_bytes, zero fill
    input  logic [0:0]  s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // out_byte, cmd_group, cmd_code, cmd_length, zero fill
    output logic [1:0]  m_tuser,   // out_kind
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int AW  = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int TXW = 8 * TX_BYTES;
    localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EXEC = 6'b000010,
        S_SEND = 6'b000100,
        S_CMD  = 6'b001000,
        S_RD   = 6'b010000,
        S_DATA = 6'b100000
    } state_t;

    typedef enum logic [4:0] {
        PH_HEADER  = 5'b00001,
        PH_PAYLOAD = 5'b00010,
        PH_AWAIT   = 5'b00100,
        PH_HDR_ACK = 5'b01000,
        PH_PAY_ACK = 5'b10000
    } phase_t;

    // configuration
    logic [7:0]  ack_reg;
    logic [7:0]  nack_reg;
    logic [15:0] timeout_reg;

    // sequencer and protocol state
    state_t      state_reg, state_next;
    phase_t      phase_reg, phase_next;
    logic [7:0]  count_reg, count_next;
    logic [7:0]  sum_reg, sum_next;
    logic [2:0]  pend_size_reg, pend_size_next;
    logic [31:0] pend_bytes_reg, pend_bytes_next;
    logic [TXW-1:0] tx_reg, tx_next;
    logic [2:0]  tx_cnt_reg, tx_cnt_next;
    logic        then_cmd_reg, then_cmd_next;
    logic [7:0]  rd_idx_reg, rd_idx_next;

    // captured input transaction
    logic        in_func_reg;
    logic [7:0]  in_byte_reg;
    logic [15:0] in_gap_reg;
    logic [2:0]  in_size_reg;
    logic [31:0] in_bytes_reg;

    // header store
    logic [7:0]  hdr_group_reg;
    logic [7:0]  hdr_code_reg;
    logic [7:0]  hdr_size_reg;
    logic        hdr_we;
    logic [1:0]  hdr_widx;

    // payload store
    logic [7:0]  pay_mem [MAX_PAYLOAD];
    logic [7:0]  rd_data_reg;
    logic        mem_we;
    logic [AW-1:0] mem_waddr;

    // result path
    logic         res_valid;
    logic         res_ready;
    scfl_result_t res;

    // derived response values
    logic [2:0]     size_sat;
    logic [7:0]     resp_hdr_sum;
    logic [TXW-1:0] resp_pay_tx;
    logic           timed_out;

    assign s_tready  = (state_reg == S_IDLE);
    assign timed_out = (in_gap_reg >= timeout_reg);
    assign size_sat  = (in_size_reg > 3'(RESP_BYTES)) ? 3'(RESP_BYTES) : in_size_reg;
    assign resp_hdr_sum = hdr_code_reg + {5'b00000, size_sat};

    // response payload bytes followed by their checksum
    always_comb
    begin
        logic [7:0] acc;
        acc         = 8'd0;
        resp_pay_tx = '0;
        for (int i = 0; i < RESP_BYTES; i++)
        begin
            if (3'(i) < pend_size_reg)
            begin
                acc = acc + pend_bytes_reg[8*i +: 8];
                resp_pay_tx[8*i +: 8] = pend_bytes_reg[8*i +: 8];
            end
        end
        for (int i = 0; i < TX_BYTES; i++)
        begin
            if (3'(i) == pend_size_reg)
            begin
                resp_pay_tx[8*i +: 8] = acc;
            end
        end
    end

    // protocol decision and result sequencing
    always_comb
    begin
        phase_t     eff_phase;
        logic [7:0] eff_count;
        logic [7:0] eff_sum;
        eff_phase       = phase_reg;
        eff_count       = count_reg;
        eff_sum         = sum_reg;
        state_next      = state_reg;
        phase_next      = phase_reg;
        count_next      = count_reg;
        sum_next        = sum_reg;
        pend_size_next  = pend_size_reg;
        pend_bytes_next = pend_bytes_reg;
        tx_next         = tx_reg;
        tx_cnt_next     = tx_cnt_reg;
        then_cmd_next   = then_cmd_reg;
        rd_idx_next     = rd_idx_reg;
        hdr_we          = 1'b0;
        hdr_widx        = count_reg[1:0];
        mem_we          = 1'b0;
        mem_waddr       = count_reg[AW-1:0];
        res_valid       = 1'b0;
        res             = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next = S_IDLE;
                if (in_func_reg)
                begin
                    // handler response: send echo, size and header checksum
                    if (phase_reg == PH_AWAIT)
                    begin
                        pend_size_next  = size_sat;
                        pend_bytes_next = in_bytes_reg;
                        tx_next         = TXW'({resp_hdr_sum, 5'b00000, size_sat, hdr_code_reg});
                        tx_cnt_next     = 3'd3;
                        then_cmd_next   = 1'b0;
                        phase_next      = PH_HDR_ACK;
                        count_next      = 8'd0;
                        state_next      = S_SEND;
                    end
                end
                else if (phase_reg != PH_AWAIT)
                begin
                    // idle gap restarts framing first
                    if (timed_out)
                    begin
                        eff_phase = PH_HEADER;
                        eff_count = 8'd0;
                        eff_sum   = 8'd0;
                    end
                    phase_next = eff_phase;
                    count_next = eff_count;
                    sum_next   = eff_sum;
                    case (eff_phase)
                        PH_HEADER:
                        begin
                            if (eff_count < 8'(HDR_LEN))
                            begin
                                hdr_we     = 1'b1;
                                hdr_widx   = eff_count[1:0];
                                sum_next   = eff_sum + in_byte_reg;
                                count_next = eff_count + 8'd1;
                            end
                            else
                            begin
                                count_next    = 8'd0;
                                sum_next      = 8'd0;
                                phase_next    = PH_HEADER;
                                tx_cnt_next   = 3'd1;
                                then_cmd_next = 1'b0;
                                state_next    = S_SEND;
                                if ((eff_sum != in_byte_reg) || (hdr_size_reg > MAX_LEN))
                                begin
                                    tx_next = TXW'(nack_reg);
                                end
                                else if (hdr_size_reg != 8'd0)
                                begin
                                    tx_next    = TXW'(ack_reg);
                                    phase_next = PH_PAYLOAD;
                                end
                                else
                                begin
                                    tx_next       = TXW'(ack_reg);
                                    then_cmd_next = 1'b1;
                                    phase_next    = PH_AWAIT;
                                end
                            end
                        end

                        PH_PAYLOAD:
                        begin
                            if ((eff_count < hdr_size_reg) && (eff_count < MAX_LEN))
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = eff_count[AW-1:0];
                                sum_next   = eff_sum + in_byte_reg;
                                count_next = eff_count + 8'd1;
                            end
                            else
                            begin
                                count_next  = 8'd0;
                                sum_next    = 8'd0;
                                tx_cnt_next = 3'd1;
                                state_next  = S_SEND;
                                if (eff_sum == in_byte_reg)
                                begin
                                    tx_next       = TXW'(ack_reg);
                                    then_cmd_next = 1'b1;
                                    phase_next    = PH_AWAIT;
                                end
                                else
                                begin
                                    tx_next       = TXW'(nack_reg);
                                    then_cmd_next = 1'b0;
                                    phase_next    = PH_HEADER;
                                end
                            end
                        end

                        PH_HDR_ACK:
                        begin
                            if ((in_byte_reg == ack_reg) && (pend_size_reg != 3'd0))
                            begin
                                tx_next       = resp_pay_tx;
                                tx_cnt_next   = pend_size_reg + 3'd1;
                                then_cmd_next = 1'b0;
                                phase_next    = PH_PAY_ACK;
                                count_next    = 8'd0;
                                state_next    = S_SEND;
                            end
                            else
                            begin
                                phase_next = PH_HEADER;
                                count_next = 8'd0;
                                sum_next   = 8'd0;
                            end
                        end

                        default:
                        begin
                            phase_next = PH_HEADER;
                            count_next = 8'd0;
                            sum_next   = 8'd0;
                        end
                    endcase
                end
            end

            S_SEND:
            begin
                // direct bytes, lowest first
                res_valid  = 1'b1;
                res.kind   = KIND_BYTE;
                res.data   = tx_reg[7:0];
                res.last   = (tx_cnt_reg == 3'd1) && !then_cmd_reg;
                if (res_ready)
                begin
                    tx_next     = tx_reg >> 8;
                    tx_cnt_next = tx_cnt_reg - 3'd1;
                    if (tx_cnt_reg == 3'd1)
                    begin
                        state_next = then_cmd_reg ? S_CMD : S_IDLE;
                    end
                end
            end

            S_CMD:
            begin
                res_valid  = 1'b1;
                res.kind   = KIND_CMD;
                res.group  = hdr_group_reg;
                res.code   = hdr_code_reg;
                res.length = hdr_size_reg[4:0];
                res.last   = (hdr_size_reg == 8'd0);
                if (res_ready)
                begin
                    rd_idx_next = 8'd0;
                    state_next  = (hdr_size_reg == 8'd0) ? S_IDLE : S_RD;
                end
            end

            S_RD:
            begin
                state_next = S_DATA;
            end

            S_DATA:
            begin
                res_valid = 1'b1;
                res.kind  = KIND_PAY;
                res.data  = rd_data_reg;
                res.last  = ((rd_idx_reg + 8'd1) == hdr_size_reg);
                if (res_ready)
                begin
                    rd_idx_next = rd_idx_reg + 8'd1;
                    state_next  = ((rd_idx_reg + 8'd1) == hdr_size_reg) ? S_IDLE : S_RD;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            phase_reg      <= PH_HEADER;
            count_reg      <= 8'd0;
            sum_reg        <= 8'd0;
            pend_size_reg  <= 3'd0;
            pend_bytes_reg <= 32'd0;
            tx_cnt_reg     <= 3'd0;
            then_cmd_reg   <= 1'b0;
            rd_idx_reg     <= 8'd0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            count_reg      <= count_next;
            sum_reg        <= sum_next;
            pend_size_reg  <= pend_size_next;
            pend_bytes_reg <= pend_bytes_next;
            tx_cnt_reg     <= tx_cnt_next;
            then_cmd_reg   <= then_cmd_next;
            rd_idx_reg     <= rd_idx_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ack_reg     <= ACK_RESET;
            nack_reg    <= NACK_RESET;
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ACK:     ack_reg     <= cfg_data[7:0];
                CFG_NACK:    nack_reg    <= cfg_data[7:0];
                CFG_TIMEOUT: timeout_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // input capture and transmit shifter
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_func_reg  <= s_tuser[0];
            in_byte_reg  <= s_tdata[7:0];
            in_gap_reg   <= s_tdata[23:8];
            in_size_reg  <= s_tdata[26:24];
            in_bytes_reg <= s_tdata[58:27];
        end
        tx_reg <= tx_next;
    end

    // header store writes
    always_ff @(posedge clk)
    begin
        if (hdr_we)
        begin
            case (hdr_widx)
                2'd0:    hdr_group_reg <= in_byte_reg;
                2'd1:    hdr_code_reg  <= in_byte_reg;
                2'd2:    hdr_size_reg  <= in_byte_reg;
                default: ;
            endcase
        end
    end

    // payload store, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            pay_mem[mem_waddr] <= in_byte_reg;
        end
        if (state_reg == S_RD)
        begin
            rd_data_reg <= pay_mem[rd_idx_reg[AW-1:0]];
        end
    end

    // output register
    scfl_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // checks
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a transaction is in progress");

    a_store_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (count_reg < MAX_LEN))
        else $error("payload store written beyond its depth");

    a_cmd_awaits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMD) |-> (phase_reg == PH_AWAIT))
        else $error("command issued without awaiting a response");

    a_read_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DATA) |-> (rd_idx_reg < hdr_size_reg))
        else $error("payload read beyond the command length");

endmodule

// ----- rtl/core/scfl_out_stage.sv -----
// ----------------------------------------------------------------------------
// scfl_out_stage
// output register between the result sequencer and the master-side stream
// ----------------------------------------------------------------------------
module scfl_out_stage
    import scfl_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         res_valid,
    input  scfl_result_t res,
    output logic         res_ready,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,   // out_byte, cmd_group, cmd_code, cmd_length, zero fill
    output logic [1:0]   m_tuser,   // out_kind
    output logic         m_tlast
);

    logic         valid_reg;
    scfl_result_t data_reg;

    // room whenever the register is empty or being drained
    assign res_ready = !valid_reg || m_tready;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            valid_reg <= res_valid;
        end
    end

    // payload register
    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            data_reg <= res;
        end
    end

    // stream packing
    assign m_tvalid = valid_reg;
    assign m_tdata  = {3'b000, data_reg.length, data_reg.code, data_reg.group, data_reg.data};
    assign m_tuser  = data_reg.kind;
    assign m_tlast  = data_reg.last;

endmodule

// ----- tb/serial_command_frame_link_checker.sv -----
// ----------------------------------------------------------------------------
// serial_command_frame_link_checker
// watches the link's streams, predicts every result and compares
// ----------------------------------------------------------------------------
// Keeps its own copy of the framing state and the three registers, follows
// configuration writes and accepted input transactions, and queues the
// results each input should cause. Every accepted result transaction is
// compared field by field with the oldest queued one. The mismatch count and
// the number of results still awaited are handed back to the test top.
// ----------------------------------------------------------------------------
module serial_command_frame_link_checker
    import scfl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,   // rx_byte, gap_ticks, resp_size, resp_bytes, zero fill
    input  logic [0:0]  s_tuser,   // func
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // out_byte, cmd_group, cmd_code, cmd_length, zero fill
    input  logic [1:0]  m_tuser,   // out_kind
    input  logic        m_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          mismatch_count,
    output int          results_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAYLOAD_MAX = 16;

    typedef enum logic [2:0] {
        LINK_HEADER,
        LINK_PAYLOAD,
        LINK_AWAIT,
        LINK_HDR_ACK,
        LINK_PAY_ACK
    } link_state_t;

    // register copies
    logic [7:0]   ack_copy;
    logic [7:0]   nack_copy;
    logic [15:0]  gap_limit;

    // framing state
    link_state_t  link_state;
    logic [7:0]   rx_count;
    logic [7:0]   hdr_bytes [HDR_LEN];
    logic [7:0]   frame_sum;
    logic [7:0]   cmd_payload [PAYLOAD_MAX];
    logic [7:0]   echo;
    logic [2:0]   reply_size;
    logic [31:0]  reply_bytes;

    // results of one input, then the store of awaited results
    scfl_result_t burst [32];
    int           burst_len;
    scfl_result_t link_results [$];
    scfl_result_t oldest;
    int           fail_count = 0;

    task automatic emit(input logic [1:0] kind, input logic [7:0] data,
                        input logic [7:0] grp, input logic [7:0] cd, input logic [4:0] len);
        scfl_result_t r;
        r.kind   = kind;
        r.data   = data;
        r.group  = grp;
        r.code   = cd;
        r.length = len;
        r.last   = 1'b0;
        burst[burst_len] = r;
        burst_len++;
    endtask

    task automatic restart_framing();
        link_state = LINK_HEADER;
        rx_count   = 8'd0;
        frame_sum  = 8'd0;
    endtask

    // ack, command record and payload, then wait for the handler
    task automatic issue_command();
        int i;
        emit(KIND_BYTE, ack_copy, 8'd0, 8'd0, 5'd0);
        emit(KIND_CMD, 8'd0, hdr_bytes[0], hdr_bytes[1], 5'(hdr_bytes[2]));
        for (i = 0; i < hdr_bytes[2]; i++)
            emit(KIND_PAY, cmd_payload[i], 8'd0, 8'd0, 5'd0);
        link_state = LINK_AWAIT;
        rx_count   = 8'd0;
        frame_sum  = 8'd0;
    endtask

    task automatic predict_link_transaction(input logic func, input logic [63:0] word);
        logic [7:0]  rx;
        logic [15:0] gap;
        logic [2:0]  rsize;
        logic [7:0]  sum;
        logic [7:0]  b;
        int          i;
        rx        = word[7:0];
        gap       = word[23:8];
        rsize     = word[26:24];
        burst_len = 0;
        if (func)
        begin
            // handler response: only answered while awaiting it
            if (link_state == LINK_AWAIT)
            begin
                reply_size  = (rsize > 3'(RESP_BYTES)) ? 3'(RESP_BYTES) : rsize;
                reply_bytes = word[58:27];
                echo        = hdr_bytes[1];
                emit(KIND_BYTE, echo, 8'd0, 8'd0, 5'd0);
                emit(KIND_BYTE, 8'(reply_size), 8'd0, 8'd0, 5'd0);
                emit(KIND_BYTE, echo + 8'(reply_size), 8'd0, 8'd0, 5'd0);
                link_state = LINK_HDR_ACK;
                rx_count   = 8'd0;
            end
        end
        else if (link_state != LINK_AWAIT)
        begin
            // idle gap restarts framing before the byte is handled
            if (gap >= gap_limit)
                restart_framing();
            case (link_state)
                LINK_HEADER:
                begin
                    if (rx_count < 8'(HDR_LEN))
                    begin
                        hdr_bytes[rx_count[1:0]] = rx;
                        frame_sum = frame_sum + rx;
                        rx_count++;
                    end
                    else
                    begin
                        sum = frame_sum;
                        restart_framing();
                        if (sum != rx || hdr_bytes[2] > PAYLOAD_MAX)
                            emit(KIND_BYTE, nack_copy, 8'd0, 8'd0, 5'd0);
                        else if (hdr_bytes[2] != 8'd0)
                        begin
                            emit(KIND_BYTE, ack_copy, 8'd0, 8'd0, 5'd0);
                            link_state = LINK_PAYLOAD;
                        end
                        else
                            issue_command();
                    end
                end
                LINK_PAYLOAD:
                begin
                    if (rx_count < hdr_bytes[2])
                    begin
                        cmd_payload[rx_count[3:0]] = rx;
                        frame_sum = frame_sum + rx;
                        rx_count++;
                    end
                    else if (frame_sum == rx)
                        issue_command();
                    else
                    begin
                        emit(KIND_BYTE, nack_copy, 8'd0, 8'd0, 5'd0);
                        restart_framing();
                    end
                end
                LINK_HDR_ACK:
                begin
                    if (rx == ack_copy && reply_size != 3'd0)
                    begin
                        sum = 8'd0;
                        for (i = 0; i < reply_size; i++)
                        begin
                            b   = reply_bytes[8*i +: 8];
                            sum = sum + b;
                            emit(KIND_BYTE, b, 8'd0, 8'd0, 5'd0);
                        end
                        emit(KIND_BYTE, sum, 8'd0, 8'd0, 5'd0);
                        link_state = LINK_PAY_ACK;
                        rx_count   = 8'd0;
                    end
                    else
                        restart_framing();
                end
                default:
                    restart_framing();
            endcase
        end
        if (burst_len > 0)
        begin
            burst[burst_len - 1].last = 1'b1;
            for (i = 0; i < burst_len; i++)
                link_results.push_back(burst[i]);
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    // follow the channels at each rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ack_copy    = ACK_RESET;
            nack_copy   = NACK_RESET;
            gap_limit   = TIMEOUT_RESET;
            restart_framing();
            hdr_bytes   = '{default: 8'd0};
            cmd_payload = '{default: 8'd0};
            echo        = 8'd0;
            reply_size  = 3'd0;
            reply_bytes = 32'd0;
            link_results.delete();
        end
        else
        begin
            // result transaction against the oldest expectation
            if (m_tvalid && m_tready)
            begin
                if (link_results.size() == 0)
                begin
                    $error("unexpected result transaction: kind %0d, byte %0d",
                           m_tuser, m_tdata[7:0]);
                    fail_count++;
                end
                else
                begin
                    oldest = link_results.pop_front();
                    check_field("out_kind", oldest.kind, m_tuser);
                    check_field("out_byte", oldest.data, m_tdata[7:0]);
                    check_field("cmd_group", oldest.group, m_tdata[15:8]);
                    check_field("cmd_code", oldest.code, m_tdata[23:16]);
                    check_field("cmd_length", oldest.length, m_tdata[28:24]);
                    check_field("last", oldest.last, m_tlast);
                end
            end
            // register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ACK:     ack_copy  = cfg_data[7:0];
                    CFG_NACK:    nack_copy = cfg_data[7:0];
                    CFG_TIMEOUT: gap_limit = cfg_data;
                    default:     ;
                endcase
            end
            // input transaction
            if (s_tvalid && s_tready)
                predict_link_transaction(s_tuser[0], s_tdata);
        end
        mismatch_count  <= fail_count;
        results_pending <= link_results.size();
    end

endmodule

// ----- tb/serial_command_frame_link_top_test.sv -----
// ----------------------------------------------------------------------------
// serial_command_frame_link_top_test
// stimulus and verdict for the serial command frame link
// ----------------------------------------------------------------------------
// Drives a directed set of frames covering acknowledged, refused and dropped
// traffic, then random command exchanges mixed with noise under several
// register settings and idling patterns on both streams. The checker beside
// the block does all prediction and comparison.
// ----------------------------------------------------------------------------
module serial_command_frame_link_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import scfl_pkg::*;

    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int PHASE_ITEMS   = 16;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata   = 64'd0;   // rx_byte, gap_ticks, resp_size, resp_bytes, zero fill
    logic [0:0]  s_tuser   = 1'b0;    // func
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;             // out_byte, cmd_group, cmd_code, cmd_length, zero fill
    logic [1:0]  m_tuser;             // out_kind
    logic        m_tlast;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = CFG_ACK;
    logic [15:0] cfg_data  = 16'd0;

    int          mismatch_count;
    int          results_pending;
    int          cycle_count    = 0;
    int          items_sent     = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    logic [7:0]  cur_ack        = ACK_RESET;
    int          cur_timeout    = TIMEOUT_RESET;

    serial_command_frame_link_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    serial_command_frame_link_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    // clock
    always #5ns clk = ~clk;

    // receiver back-pressure
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // run watchdog
    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("FAIL");
        $finish;
    end

    task automatic send_item(input logic func, input logic [7:0] rx, input logic [15:0] gap,
                             input logic [2:0] rsize, input logic [31:0] rword);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {5'd0, rword, rsize, gap, rx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    // host byte; the response fields carry noise
    task automatic send_byte(input logic [7:0] rx, input logic [15:0] gap);
        send_item(1'b0, rx, gap, 3'($urandom_range(7)), $urandom());
    endtask

    // handler response; the byte fields carry noise
    task automatic send_reply(input logic [2:0] rsize, input logic [31:0] rword);
        send_item(1'b1, 8'($urandom_range(255)), 16'($urandom_range(65535)), rsize, rword);
    endtask

    // gap at or above the timeout when a restart is wanted, below it otherwise (any gap at a zero timeout)
    function automatic logic [15:0] pick_gap(input bit restart);
        if (restart)
            return 16'($urandom_range(65535, cur_timeout));
        if (cur_timeout == 0)
            return 16'($urandom_range(65535));
        return 16'($urandom_range(cur_timeout - 1, 0));
    endfunction

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic load_config(input logic [7:0] ack, input logic [7:0] nack,
                               input logic [15:0] timeout);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ACK;
        cfg_data  <= {8'd0, ack};
        @(posedge clk);
        cfg_index <= CFG_NACK;
        cfg_data  <= {8'd0, nack};
        @(posedge clk);
        cfg_index <= CFG_TIMEOUT;
        cfg_data  <= timeout;
        @(posedge clk);
        cfg_we      <= 1'b0;
        cur_ack     = ack;
        cur_timeout = timeout;
    endtask

    // one command exchange, now and then with a broken checksum, an oversized length or a stray byte
    task automatic run_exchange();
        logic [7:0] grp;
        logic [7:0] cd;
        logic [7:0] len;
        logic [7:0] hsum;
        logic [7:0] psum;
        logic [7:0] b;
        int         sel;
        bit         bad_hdr;
        bit         bad_pay;
        grp = 8'($urandom());
        cd  = 8'($urandom());
        sel = $urandom_range(9);
        if (sel < 6)
            len = 8'($urandom_range(4));
        else if (sel < 8)
            len = 8'($urandom_range(16));
        else if (sel == 8)
            len = 8'd16;
        else
            len = 8'($urandom_range(255, 17));
        bad_hdr = ($urandom_range(9) == 0);
        bad_pay = ($urandom_range(9) == 0);
        hsum    = grp + cd + len;
        send_byte(grp, pick_gap(bit'($urandom_range(1))));
        send_byte(cd, pick_gap(1'b0));
        send_byte(len, pick_gap(1'b0));
        send_byte(bad_hdr ? hsum ^ 8'($urandom_range(255, 1)) : hsum, pick_gap(1'b0));
        if (!bad_hdr && len != 8'd0 && len <= 8'd16)
        begin
            psum = 8'd0;
            repeat (len)
            begin
                b    = 8'($urandom());
                psum = psum + b;
                send_byte(b, pick_gap(1'b0));
            end
            send_byte(bad_pay ? psum ^ 8'($urandom_range(255, 1)) : psum, pick_gap(1'b0));
        end
        // stray byte, dropped if the handler is awaited
        if ($urandom_range(7) == 0)
            send_byte(8'($urandom()), pick_gap(bit'($urandom_range(1))));
        send_reply(3'($urandom_range(7)), $urandom());
        send_byte(($urandom_range(4) != 0) ? cur_ack : 8'($urandom()), pick_gap(1'b0));
        send_byte(8'($urandom()), pick_gap(bit'($urandom_range(1))));
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int quota);
        int target;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        target         = items_sent + quota;
        while (items_sent < target)
        begin
            if ($urandom_range(4) == 0)
            begin
                if ($urandom_range(1) == 0)
                    send_byte(8'($urandom()), 16'($urandom_range(65535)));
                else
                    send_reply(3'($urandom_range(7)), $urandom());
            end
            else
                run_exchange();
        end
        wait_idle();
    endtask

    initial
    begin
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // size-zero command with extreme header bytes, idle header restart first
        send_byte(8'hFF, 16'hFFFF);
        send_byte(8'h00, 16'd0);
        send_byte(8'h00, 16'd0);
        send_byte(8'hFF, 16'd0);
        // byte while the handler is awaited: dropped, no timeout check
        send_byte(8'hAA, 16'hFFFF);
        // oversized response size, saturated
        send_reply(3'd7, 32'hFFFF_FFFF);
        send_byte(ACK_RESET, 16'd0);
        // byte after the response payload
        send_byte(8'h00, 16'd0);
        // response item outside the await phase
        send_reply(3'd2, 32'h0000_0000);
        // oversized command
        send_byte(8'h01, 16'd4999);
        send_byte(8'h02, 16'd0);
        send_byte(8'h11, 16'd0);
        send_byte(8'h14, 16'd0);
        // bad header checksum
        send_byte(8'h03, 16'd0);
        send_byte(8'h04, 16'd0);
        send_byte(8'h00, 16'd0);
        send_byte(8'h00, 16'd0);
        // bad payload checksum
        send_byte(8'h05, 16'd0);
        send_byte(8'h06, 16'd0);
        send_byte(8'h01, 16'd0);
        send_byte(8'h0C, 16'd0);
        send_byte(8'h80, 16'd0);
        send_byte(8'h81, 16'd0);
        // refusal of the response header
        send_byte(8'h07, 16'd0);
        send_byte(8'h08, 16'd0);
        send_byte(8'h00, 16'd0);
        send_byte(8'h0F, 16'd0);
        send_reply(3'd3, 32'h0012_3456);
        send_byte(NACK_RESET, 16'd0);
        wait_idle();

        // random exchanges under several settings and idling patterns
        run_phase(0, 0, PHASE_ITEMS);
        load_config(8'hFF, 8'h00, 16'hFFFF);
        run_phase(77, 0, PHASE_ITEMS);
        load_config(8'h00, 8'hFF, 16'd1);
        run_phase(0, 77, PHASE_ITEMS);
        load_config(8'($urandom()), 8'($urandom()), 16'($urandom_range(2000, 2)));
        run_phase(21, 21, PHASE_ITEMS);
        // zero timeout: every byte restarts framing
        load_config(ACK_RESET, NACK_RESET, 16'd0);
        run_phase(0, 0, 8);

        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/scfl_pkg.sv
rtl/core/scfl_out_stage.sv
rtl/core/serial_command_frame_link_top.sv
tb/serial_command_frame_link_checker.sv
tb/serial_command_frame_link_top_test.sv
